@@ hdl/tlx_pkg.sv @@
// ---------------------------------------------------------------------------
// tlx_pkg: shared types and constants of the token lexer stream
// Field widths, token kinds, error codes, scan modes and the item structs.
// ---------------------------------------------------------------------------
package tlx_pkg;

    localparam int MAX_WORD_LEN = 255;
    localparam int OFFSET_BITS  = 24;

    localparam int CNT_W   = 24;
    localparam int LIT_W   = 63;
    localparam int KIND_W  = 4;
    localparam int LEN_W   = 8;
    localparam int ERR_W   = 2;
    localparam int PFX_W   = 48;
    localparam int WCNT_W  = $clog2(MAX_WORD_LEN + 1);
    localparam int OFFX_W  = (OFFSET_BITS > CNT_W) ? OFFSET_BITS : CNT_W;
    localparam int WLENX_W = (WCNT_W > LEN_W) ? WCNT_W : LEN_W;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_NUM     = 2'd1;
    localparam logic [1:0] MODE_WORD    = 2'd2;
    localparam logic [1:0] MODE_DISCARD = 2'd3;

    localparam logic [KIND_W-1:0] KIND_LPAREN = 4'd0;
    localparam logic [KIND_W-1:0] KIND_RPAREN = 4'd1;
    localparam logic [KIND_W-1:0] KIND_LBRACE = 4'd2;
    localparam logic [KIND_W-1:0] KIND_RBRACE = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SEMI   = 4'd4;
    localparam logic [KIND_W-1:0] KIND_INT    = 4'd5;
    localparam logic [KIND_W-1:0] KIND_VOID   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_RETURN = 4'd7;
    localparam logic [KIND_W-1:0] KIND_IDENT  = 4'd8;
    localparam logic [KIND_W-1:0] KIND_LIT    = 4'd9;
    localparam logic [KIND_W-1:0] KIND_ERR    = 4'd10;
    localparam logic [KIND_W-1:0] KIND_END    = 4'd11;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNKNOWN  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OVERFLOW = 2'd2;
    localparam logic [ERR_W-1:0] ERR_BAD_LIT  = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in_item;

    typedef struct packed {
        logic [KIND_W-1:0] tok_kind;
        logic [LIT_W-1:0]  literal_value;
        logic [CNT_W-1:0]  word_offset;
        logic [LEN_W-1:0]  word_length;
        logic [ERR_W-1:0]  error_code;
        logic [CNT_W-1:0]  error_line;
        logic [CNT_W-1:0]  error_column;
        logic              run_end;
    } t_result;

    // Results of one item, handed from the scanner to the output stage.
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

endpackage

@@ hdl/tlx_if.sv @@
// ---------------------------------------------------------------------------
// tlx_if: stream channels of the token lexer
// Valid/ready channels for source bytes and for token results.
// ---------------------------------------------------------------------------
interface tlx_in_if;
    logic              valid;
    logic              ready;
    tlx_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tlx_out_if;
    logic             valid;
    logic             ready;
    tlx_pkg::t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/tlx_core.sv @@
// ---------------------------------------------------------------------------
// tlx_core: input register, scan state and per-byte token logic
// Classifies one registered item per cycle when i_load_ok; up to two results.
// ---------------------------------------------------------------------------
module tlx_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    tlx_in_if.sink         i_text,
    input  logic           i_load_ok,
    output tlx_pkg::t_push o_push
);

    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NL   = 8'h0A;
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_INT    = 48'h0000_0069_6E74;
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_VOID   = 48'h0000_766F_6964;
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_RETURN = 48'h7265_7475_726E;
    localparam logic [tlx_pkg::CNT_W-1:0] CNT_MAX = {tlx_pkg::CNT_W{1'b1}};
    localparam logic [tlx_pkg::OFFSET_BITS-1:0] OFF_MAX = {tlx_pkg::OFFSET_BITS{1'b1}};
    localparam logic [tlx_pkg::WCNT_W-1:0] WCNT_MAX = tlx_pkg::WCNT_W'(tlx_pkg::MAX_WORD_LEN);

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c == 8'h5F);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    logic                                r_in_valid;
    tlx_pkg::t_in_item                   r_in;
    logic [1:0]                          r_mode,   n_mode;
    logic [tlx_pkg::LIT_W-1:0]           r_acc,    n_acc;
    logic [tlx_pkg::PFX_W-1:0]           r_prefix, n_prefix;
    logic [tlx_pkg::WCNT_W-1:0]          r_wcount, n_wcount;
    logic [tlx_pkg::OFFSET_BITS-1:0]     r_wstart, n_wstart;
    logic [tlx_pkg::OFFSET_BITS-1:0]     r_offset, n_offset;
    logic [tlx_pkg::CNT_W-1:0]           r_line,   n_line;
    logic [tlx_pkg::CNT_W-1:0]           r_col,    n_col;

    logic                                fire;
    logic [7:0]                          c;
    logic [3:0]                          digit;
    logic [tlx_pkg::LIT_W+3:0]           acc_x10;
    logic                                acc_ovf;
    logic                                c_digit;
    logic                                c_word;
    tlx_pkg::t_result                    lit_res;
    tlx_pkg::t_result                    word_res;
    tlx_pkg::t_result                    end_res;
    tlx_pkg::t_result                    idle_res;
    logic                                idle_emit;
    logic [1:0]                          idle_mode;
    logic [tlx_pkg::OFFX_W-1:0]          wstart_x;
    logic [tlx_pkg::WLENX_W-1:0]         wlen_x;
    logic                                do_idle;
    logic                                v0, v1;
    tlx_pkg::t_result                    slot0, slot1;

    assign fire         = r_in_valid && i_load_ok;
    assign i_text.ready = !r_in_valid || fire;

    assign c       = r_in.text_byte;
    assign digit   = 4'(c - CH_ZERO);
    assign c_digit = is_digit(c);
    assign c_word  = is_word_start(c);

    // Ten times the value plus the digit; any bit above bit 62 is an overflow.
    assign acc_x10 = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1)
                   + (tlx_pkg::LIT_W + 4)'(digit);
    assign acc_ovf = |acc_x10[tlx_pkg::LIT_W+3:tlx_pkg::LIT_W];

    assign wstart_x = tlx_pkg::OFFX_W'(r_wstart);
    assign wlen_x   = tlx_pkg::WLENX_W'(r_wcount);

    always_comb begin
        lit_res               = '0;
        lit_res.tok_kind      = tlx_pkg::KIND_LIT;
        lit_res.literal_value = r_acc;

        end_res          = '0;
        end_res.tok_kind = tlx_pkg::KIND_END;

        word_res = '0;
        if (r_wcount == tlx_pkg::WCNT_W'(3) && r_prefix == PFX_INT) begin
            word_res.tok_kind = tlx_pkg::KIND_INT;
        end else if (r_wcount == tlx_pkg::WCNT_W'(4) && r_prefix == PFX_VOID) begin
            word_res.tok_kind = tlx_pkg::KIND_VOID;
        end else if (r_wcount == tlx_pkg::WCNT_W'(6) && r_prefix == PFX_RETURN) begin
            word_res.tok_kind = tlx_pkg::KIND_RETURN;
        end else begin
            word_res.tok_kind    = tlx_pkg::KIND_IDENT;
            word_res.word_offset = wstart_x[tlx_pkg::CNT_W-1:0];
            word_res.word_length = (wlen_x > tlx_pkg::WLENX_W'(255)) ? 8'hFF
                                                                     : wlen_x[7:0];
        end
    end

    // What a byte does when no literal or word is open.
    always_comb begin
        idle_emit = 1'b1;
        idle_mode = tlx_pkg::MODE_IDLE;
        idle_res  = '0;
        case (c)
            8'h28: idle_res.tok_kind = tlx_pkg::KIND_LPAREN;
            8'h29: idle_res.tok_kind = tlx_pkg::KIND_RPAREN;
            8'h7B: idle_res.tok_kind = tlx_pkg::KIND_LBRACE;
            8'h7D: idle_res.tok_kind = tlx_pkg::KIND_RBRACE;
            8'h3B: idle_res.tok_kind = tlx_pkg::KIND_SEMI;
            default: begin
                if (is_space(c)) begin
                    idle_emit = 1'b0;
                end else if (c_digit) begin
                    idle_emit = 1'b0;
                    idle_mode = tlx_pkg::MODE_NUM;
                end else if (c_word) begin
                    idle_emit = 1'b0;
                    idle_mode = tlx_pkg::MODE_WORD;
                end else begin
                    idle_mode             = tlx_pkg::MODE_DISCARD;
                    idle_res.tok_kind     = tlx_pkg::KIND_ERR;
                    idle_res.error_code   = tlx_pkg::ERR_UNKNOWN;
                    idle_res.error_line   = r_line;
                    idle_res.error_column = r_col;
                end
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_acc    = r_acc;
        n_prefix = r_prefix;
        n_wcount = r_wcount;
        n_wstart = r_wstart;
        n_offset = r_offset;
        n_line   = r_line;
        n_col    = r_col;
        v0       = 1'b0;
        v1       = 1'b0;
        slot0    = '0;
        slot1    = '0;
        do_idle  = 1'b0;

        if (r_in.end_of_text) begin
            if (r_mode == tlx_pkg::MODE_NUM) begin
                v0    = 1'b1;
                slot0 = lit_res;
            end else if (r_mode == tlx_pkg::MODE_WORD) begin
                v0    = 1'b1;
                slot0 = word_res;
            end
            // The end token follows an open literal or word, else it goes first.
            if (v0) begin
                v1    = 1'b1;
                slot1 = end_res;
            end else begin
                v0    = 1'b1;
                slot0 = end_res;
            end
            n_mode   = tlx_pkg::MODE_IDLE;
            n_acc    = '0;
            n_prefix = '0;
            n_wcount = '0;
            n_wstart = '0;
            n_offset = '0;
            n_line   = tlx_pkg::CNT_W'(1);
            n_col    = '0;
        end else begin
            case (r_mode)
                tlx_pkg::MODE_NUM: begin
                    if (c_digit) begin
                        if (acc_ovf) begin
                            v0                 = 1'b1;
                            slot0.tok_kind     = tlx_pkg::KIND_ERR;
                            slot0.error_code   = tlx_pkg::ERR_OVERFLOW;
                            slot0.error_line   = r_line;
                            slot0.error_column = r_col;
                            n_mode             = tlx_pkg::MODE_DISCARD;
                        end else begin
                            n_acc = acc_x10[tlx_pkg::LIT_W-1:0];
                        end
                    end else if (c_word) begin
                        v0                 = 1'b1;
                        slot0.tok_kind     = tlx_pkg::KIND_ERR;
                        slot0.error_code   = tlx_pkg::ERR_BAD_LIT;
                        slot0.error_line   = r_line;
                        slot0.error_column = r_col;
                        n_mode             = tlx_pkg::MODE_DISCARD;
                    end else begin
                        v0      = 1'b1;
                        slot0   = lit_res;
                        do_idle = 1'b1;
                    end
                end
                tlx_pkg::MODE_WORD: begin
                    if (c_word || c_digit) begin
                        if (r_wcount < tlx_pkg::WCNT_W'(6)) begin
                            n_prefix = {r_prefix[tlx_pkg::PFX_W-9:0], c};
                        end
                        if (r_wcount < WCNT_MAX) begin
                            n_wcount = r_wcount + tlx_pkg::WCNT_W'(1);
                        end
                    end else begin
                        v0      = 1'b1;
                        slot0   = word_res;
                        do_idle = 1'b1;
                    end
                end
                tlx_pkg::MODE_IDLE: begin
                    do_idle = 1'b1;
                end
                default: begin
                end
            endcase

            if (do_idle) begin
                n_mode = idle_mode;
                if (idle_mode == tlx_pkg::MODE_NUM) begin
                    n_acc = tlx_pkg::LIT_W'(digit);
                end
                if (idle_mode == tlx_pkg::MODE_WORD) begin
                    n_prefix = tlx_pkg::PFX_W'(c);
                    n_wcount = tlx_pkg::WCNT_W'(1);
                    n_wstart = r_offset;
                end
                if (idle_emit) begin
                    if (v0) begin
                        v1    = 1'b1;
                        slot1 = idle_res;
                    end else begin
                        v0    = 1'b1;
                        slot0 = idle_res;
                    end
                end
            end

            if (r_offset < OFF_MAX) begin
                n_offset = r_offset + tlx_pkg::OFFSET_BITS'(1);
            end
            if (c == CH_NL) begin
                if (r_line < CNT_MAX) begin
                    n_line = r_line + tlx_pkg::CNT_W'(1);
                end
                n_col = '0;
            end else if (r_col < CNT_MAX) begin
                n_col = r_col + tlx_pkg::CNT_W'(1);
            end
        end

        if (v1) begin
            slot1.run_end = 1'b1;
        end else if (v0) begin
            slot0.run_end = 1'b1;
        end
    end

    always_comb begin
        o_push.count  = fire ? ({1'b0, v0} + {1'b0, v1}) : 2'd0;
        o_push.first  = slot0;
        o_push.second = slot1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_text.valid && i_text.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_text.valid && i_text.ready) begin
            r_in <= i_text.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= tlx_pkg::MODE_IDLE;
            r_acc    <= '0;
            r_prefix <= '0;
            r_wcount <= '0;
            r_wstart <= '0;
            r_offset <= '0;
            r_line   <= tlx_pkg::CNT_W'(1);
            r_col    <= '0;
        end else if (fire) begin
            r_mode   <= n_mode;
            r_acc    <= n_acc;
            r_prefix <= n_prefix;
            r_wcount <= n_wcount;
            r_wstart <= n_wstart;
            r_offset <= n_offset;
            r_line   <= n_line;
            r_col    <= n_col;
        end
    end

endmodule

@@ hdl/tlx_outq.sv @@
// ---------------------------------------------------------------------------
// tlx_outq: two-entry result stage of the token lexer
// Holds the results of one item and presents them in order on the output.
// ---------------------------------------------------------------------------
module tlx_outq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlx_pkg::t_push i_push,
    output logic           o_load_ok,
    tlx_out_if.source      o_tok
);

    logic [1:0]       r_count;
    tlx_pkg::t_result r_slot0;
    tlx_pkg::t_result r_slot1;
    logic             pop;

    assign pop         = o_tok.valid && o_tok.ready;
    assign o_tok.valid = (r_count != 2'd0);
    assign o_tok.data  = r_slot0;

    // New results may load once everything held will have left by this edge.
    assign o_load_ok = (r_count == 2'd0) || ((r_count == 2'd1) && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (o_load_ok) begin
            r_count <= i_push.count;
        end else if (pop) begin
            r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load_ok) begin
            r_slot0 <= i_push.first;
            r_slot1 <= i_push.second;
        end else if (pop) begin
            r_slot0 <= r_slot1;
        end
    end

endmodule

@@ hdl/token_lexer_stream.sv @@
// ---------------------------------------------------------------------------
// token_lexer_stream: streaming lexer for a small C subset
// Turns a byte stream into tokens, literals, identifiers and errors.
// ---------------------------------------------------------------------------
// Source bytes enter on i_text, one item per cycle while the result stage
// can take them; an item with end_of_text set closes the text, emits any
// open literal or word and then the end token, and returns all counters to
// their reset values. Each item is held in an input register and scanned
// into a two-entry result register; the scan waits while that register is
// still busy. An item that yields at most one result is taken every cycle
// while o_tok is ready; an item that yields two results (a token that closes
// a literal or word, or end of text after one) holds off the next item until
// its second result is leaving the result register.
module token_lexer_stream (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlx_in_if.sink    i_text,
    tlx_out_if.source o_tok
);

    tlx_pkg::t_push push;
    logic           load_ok;

    tlx_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_text    (i_text),
        .i_load_ok (load_ok),
        .o_push    (push)
    );

    tlx_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_load_ok (load_ok),
        .o_tok     (o_tok)
    );

endmodule

@@ tb/token_lexer_stream_tb.sv @@
// ---------------------------------------------------------------------------
// token_lexer_stream_tb: self-checking testbench of the token lexer stream
// Feeds source bytes and end-of-text items with random gaps on both sides,
// predicts every token, literal, identifier and error in a model of the
// lexer kept here, and compares each result item field by field in order.
// ---------------------------------------------------------------------------
module token_lexer_stream_tb;

    localparam int STALL_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1100;
    localparam int SCRIPT_ROWS  = 24;

    localparam logic [7:0]  CH_TAB = 8'h09;
    localparam logic [7:0]  CH_LF  = 8'h0A;
    localparam logic [63:0] LIT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // Packed first bytes of each keyword, right aligned.
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_INT    = "int";
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_VOID   = "void";
    localparam logic [tlx_pkg::PFX_W-1:0] PFX_RETURN = "return";

    // Marks a script row whose last result is left to the lexer model alone.
    localparam logic [tlx_pkg::KIND_W-1:0] NO_TOKEN = 4'hF;

    typedef struct packed {
        logic [7:0]                 text_byte;
        logic                       end_of_text;
        logic [tlx_pkg::KIND_W-1:0] last_kind;
        logic [tlx_pkg::ERR_W-1:0]  last_err;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;

    tlx_in_if  text_if ();
    tlx_out_if tok_if ();

    token_lexer_stream u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (text_if),
        .o_tok   (tok_if)
    );

    // Lexer model state.
    logic [1:0]                      lex_mode;
    logic [tlx_pkg::LIT_W-1:0]       lit_acc;
    logic [tlx_pkg::PFX_W-1:0]       word_pfx;
    int                              word_len;
    logic [tlx_pkg::OFFSET_BITS-1:0] word_begin;
    logic [tlx_pkg::OFFSET_BITS-1:0] src_offset;
    logic [tlx_pkg::CNT_W-1:0]       src_line;
    logic [tlx_pkg::CNT_W-1:0]       src_col;

    tlx_pkg::t_result found [2];
    int               n_found;
    tlx_pkg::t_result expected_tokens [$];
    tlx_pkg::t_result want;
    t_script_row      script [SCRIPT_ROWS];

    int mismatches   = 0;
    int stall_cycles = 0;
    int live_items   = 0;
    int next_long_at = 200;
    bit calm         = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------- lexer model ----------------

    function automatic bit is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_space(logic [7:0] c);
        return c == " " || (c >= CH_TAB && c <= 8'h0D);
    endfunction

    function automatic void clear_lexer();
        lex_mode   = tlx_pkg::MODE_IDLE;
        lit_acc    = '0;
        word_pfx   = '0;
        word_len   = 0;
        word_begin = '0;
        src_offset = '0;
        src_line   = tlx_pkg::CNT_W'(1);
        src_col    = '0;
    endfunction

    function automatic void add_token(logic [tlx_pkg::KIND_W-1:0] kind,
                                      logic [tlx_pkg::LIT_W-1:0] value,
                                      logic [tlx_pkg::CNT_W-1:0] offset,
                                      logic [tlx_pkg::LEN_W-1:0] length,
                                      logic [tlx_pkg::ERR_W-1:0] code,
                                      logic [tlx_pkg::CNT_W-1:0] line,
                                      logic [tlx_pkg::CNT_W-1:0] column);
        tlx_pkg::t_result r;
        r.tok_kind      = kind;
        r.literal_value = value;
        r.word_offset   = offset;
        r.word_length   = length;
        r.error_code    = code;
        r.error_line    = line;
        r.error_column  = column;
        r.run_end       = 1'b0;
        found[n_found]  = r;
        n_found++;
    endfunction

    function automatic void flag_error(logic [tlx_pkg::ERR_W-1:0] code);
        add_token(tlx_pkg::KIND_ERR, '0, '0, '0, code, src_line, src_col);
        lex_mode = tlx_pkg::MODE_DISCARD;
    endfunction

    function automatic void close_word();
        if (word_len == 3 && word_pfx == PFX_INT)
            add_token(tlx_pkg::KIND_INT, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
        else if (word_len == 4 && word_pfx == PFX_VOID)
            add_token(tlx_pkg::KIND_VOID, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
        else if (word_len == 6 && word_pfx == PFX_RETURN)
            add_token(tlx_pkg::KIND_RETURN, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
        else
            add_token(tlx_pkg::KIND_IDENT, '0, tlx_pkg::CNT_W'(word_begin),
                      (word_len > 255) ? 8'd255 : tlx_pkg::LEN_W'(word_len),
                      tlx_pkg::ERR_NONE, '0, '0);
        lex_mode = tlx_pkg::MODE_IDLE;
    endfunction

    function automatic void idle_byte(logic [7:0] c);
        case (c)
            "(": add_token(tlx_pkg::KIND_LPAREN, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            ")": add_token(tlx_pkg::KIND_RPAREN, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            "{": add_token(tlx_pkg::KIND_LBRACE, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            "}": add_token(tlx_pkg::KIND_RBRACE, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            ";": add_token(tlx_pkg::KIND_SEMI, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            default: begin
                if (is_space(c)) begin
                end else if (is_digit(c)) begin
                    lit_acc  = tlx_pkg::LIT_W'(c - "0");
                    lex_mode = tlx_pkg::MODE_NUM;
                end else if (is_word_char(c)) begin
                    word_pfx   = tlx_pkg::PFX_W'(c);
                    word_len   = 1;
                    word_begin = src_offset;
                    lex_mode   = tlx_pkg::MODE_WORD;
                end else begin
                    flag_error(tlx_pkg::ERR_UNKNOWN);
                end
            end
        endcase
    endfunction

    function automatic void predict_tokens(logic [7:0] c, logic eot);
        logic [63:0] digit;
        n_found = 0;
        digit   = 64'(c) - 64'(8'h30);
        if (eot) begin
            if (lex_mode == tlx_pkg::MODE_NUM)
                add_token(tlx_pkg::KIND_LIT, lit_acc, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            else if (lex_mode == tlx_pkg::MODE_WORD)
                close_word();
            add_token(tlx_pkg::KIND_END, '0, '0, '0, tlx_pkg::ERR_NONE, '0, '0);
            clear_lexer();
        end else begin
            case (lex_mode)
                tlx_pkg::MODE_NUM: begin
                    if (is_digit(c)) begin
                        if ({1'b0, lit_acc} > (LIT_MAX - digit) / 64'd10)
                            flag_error(tlx_pkg::ERR_OVERFLOW);
                        else
                            lit_acc = lit_acc * 63'd10 + digit[tlx_pkg::LIT_W-1:0];
                    end else if (is_word_char(c)) begin
                        flag_error(tlx_pkg::ERR_BAD_LIT);
                    end else begin
                        add_token(tlx_pkg::KIND_LIT, lit_acc, '0, '0,
                                  tlx_pkg::ERR_NONE, '0, '0);
                        lex_mode = tlx_pkg::MODE_IDLE;
                        idle_byte(c);
                    end
                end
                tlx_pkg::MODE_WORD: begin
                    if (is_word_char(c) || is_digit(c)) begin
                        if (word_len < 6)
                            word_pfx = {word_pfx[tlx_pkg::PFX_W-9:0], c};
                        if (word_len < tlx_pkg::MAX_WORD_LEN)
                            word_len++;
                    end else begin
                        close_word();
                        idle_byte(c);
                    end
                end
                tlx_pkg::MODE_IDLE: idle_byte(c);
                default: begin
                end
            endcase
            if (src_offset != '1)
                src_offset++;
            if (c == CH_LF) begin
                if (src_line != '1)
                    src_line++;
                src_col = '0;
            end else if (src_col != '1) begin
                src_col++;
            end
        end
        if (n_found > 0)
            found[n_found-1].run_end = 1'b1;
        for (int i = 0; i < n_found; i++)
            expected_tokens.push_back(found[i]);
    endfunction

    // ---------------- stimulus ----------------

    task automatic drive_item(input logic [7:0] b, input logic eot);
        if (!calm) begin
            while ($urandom_range(0, 99) < 27) begin
                text_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        text_if.valid <= 1'b1;
        text_if.data  <= '{text_byte: b, end_of_text: eot};
        @(posedge i_clk);
        while (!text_if.ready)
            @(posedge i_clk);
        // Bytes swallowed after an error do not count toward the random budget.
        if (lex_mode != tlx_pkg::MODE_DISCARD)
            live_items++;
        predict_tokens(b, eot);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            drive_item(s[i], 1'b0);
    endtask

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 7))
            0, 1:    return " ";
            2, 3:    return CH_LF;
            4:       return CH_TAB;
            5:       return 8'h0B;
            6:       return 8'h0C;
            default: return 8'h0D;
        endcase
    endfunction

    function automatic logic [7:0] pick_punct();
        case ($urandom_range(0, 4))
            0:       return "(";
            1:       return ")";
            2:       return "{";
            3:       return "}";
            default: return ";";
        endcase
    endfunction

    function automatic logic [7:0] pick_word_char(bit first);
        int r;
        r = first ? $urandom_range(0, 52) : $urandom_range(0, 62);
        if (r < 26)
            return 8'("a" + r);
        else if (r < 52)
            return 8'("A" + r - 26);
        else if (r == 52)
            return "_";
        else
            return 8'("0" + r - 53);
    endfunction

    task automatic send_digits(input int count);
        for (int i = 0; i < count; i++)
            drive_item(8'("0" + $urandom_range(0, 9)), 1'b0);
    endtask

    task automatic send_word(input int count);
        for (int i = 0; i < count; i++)
            drive_item(pick_word_char(i == 0), 1'b0);
    endtask

    task automatic random_text();
        int  sel;
        int  len;
        bit  tail;
        while (live_items < RANDOM_ITEMS) begin
            calm = live_items >= 450 && live_items < 650;
            tail = 1'b0;
            sel  = $urandom_range(0, 99);
            if (sel < 20) begin
                drive_item(pick_punct(), 1'b0);
            end else if (sel < 32) begin
                drive_item(pick_space(), 1'b0);
            end else if (sel < 42) begin
                case ($urandom_range(0, 2))
                    0:       send_text("int");
                    1:       send_text("void");
                    default: send_text("return");
                endcase
                tail = 1'b1;
            end else if (sel < 57) begin
                // A couple of words run near or past the length limit to reach saturation.
                if (live_items >= next_long_at) begin
                    len = $urandom_range(254, 300);
                    next_long_at += 500;
                end else begin
                    len = $urandom_range(1, 8);
                end
                send_word(len);
                tail = 1'b1;
            end else if (sel < 72) begin
                case ($urandom_range(0, 9))
                    0:       send_text("9223372036854775807");
                    1:       send_text("9223372036854775808");
                    2:       send_digits($urandom_range(17, 20));
                    default: send_digits($urandom_range(1, 6));
                endcase
                tail = 1'b1;
            end else if (sel < 78) begin
                case ($urandom_range(0, 5))
                    0:       send_text("Int");
                    1:       send_text("_void");
                    2:       send_text("retur");
                    3:       send_text("ints");
                    4:       send_text("voids");
                    default: send_text("returns");
                endcase
                tail = 1'b1;
            end else if (sel < 86) begin
                drive_item(8'($urandom_range(0, 255)), 1'b0);
            end else if (sel < 90) begin
                send_digits($urandom_range(1, 3));
                drive_item(pick_word_char(1'b1), 1'b0);
            end else begin
                drive_item(8'($urandom_range(0, 255)), 1'b1);
            end
            if (tail && $urandom_range(0, 4) != 0)
                drive_item(($urandom_range(0, 1) != 0) ? pick_space() : pick_punct(), 1'b0);
            // After an error, drop a few bytes and close the text.
            if (lex_mode == tlx_pkg::MODE_DISCARD) begin
                repeat ($urandom_range(0, 3))
                    drive_item(8'($urandom_range(0, 255)), 1'b0);
                drive_item(8'($urandom_range(0, 255)), 1'b1);
            end
        end
        calm = 1'b0;
        drive_item(8'($urandom_range(0, 255)), 1'b1);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        text_if.valid <= 1'b0;
        text_if.data  <= '0;
        clear_lexer();

        script = '{
            '{"(",    1'b0, tlx_pkg::KIND_LPAREN, tlx_pkg::ERR_NONE},
            '{")",    1'b0, tlx_pkg::KIND_RPAREN, tlx_pkg::ERR_NONE},
            '{"{",    1'b0, tlx_pkg::KIND_LBRACE, tlx_pkg::ERR_NONE},
            '{"}",    1'b0, tlx_pkg::KIND_RBRACE, tlx_pkg::ERR_NONE},
            '{";",    1'b0, tlx_pkg::KIND_SEMI,   tlx_pkg::ERR_NONE},
            '{"i",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{"n",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{"t",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{" ",    1'b0, tlx_pkg::KIND_INT,    tlx_pkg::ERR_NONE},
            '{"9",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{")",    1'b0, tlx_pkg::KIND_RPAREN, tlx_pkg::ERR_NONE},
            '{CH_TAB, 1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{"x",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{"7",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{")",    1'b1, tlx_pkg::KIND_END,    tlx_pkg::ERR_NONE},
            '{"0",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{"a",    1'b0, tlx_pkg::KIND_ERR,    tlx_pkg::ERR_BAD_LIT},
            '{"b",    1'b0, NO_TOKEN,             tlx_pkg::ERR_NONE},
            '{8'h00,  1'b1, tlx_pkg::KIND_END,    tlx_pkg::ERR_NONE},
            '{8'hFF,  1'b0, tlx_pkg::KIND_ERR,    tlx_pkg::ERR_UNKNOWN},
            '{8'hFF,  1'b1, tlx_pkg::KIND_END,    tlx_pkg::ERR_NONE},
            '{8'h00,  1'b0, tlx_pkg::KIND_ERR,    tlx_pkg::ERR_UNKNOWN},
            '{8'h00,  1'b1, tlx_pkg::KIND_END,    tlx_pkg::ERR_NONE},
            '{8'h00,  1'b1, tlx_pkg::KIND_END,    tlx_pkg::ERR_NONE}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < SCRIPT_ROWS; i++) begin
            drive_item(script[i].text_byte, script[i].end_of_text);
            if (script[i].last_kind != NO_TOKEN) begin
                if (n_found == 0 || found[n_found-1].tok_kind != script[i].last_kind ||
                    found[n_found-1].error_code != script[i].last_err) begin
                    $display("%0t: script row %0d expected kind %0d code %0d", $time, i,
                             script[i].last_kind, script[i].last_err);
                    mismatches++;
                end
            end
        end

        live_items = 0;
        random_text();
        text_if.valid <= 1'b0;

        while (expected_tokens.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ---------------- result side ----------------

    always @(posedge i_clk) begin
        tok_if.ready <= calm || ($urandom_range(0, 99) >= 27);
    end

    function automatic void check_field(string name, logic [63:0] got, logic [63:0] exp_val);
        if (got !== exp_val) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_val, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && tok_if.valid && tok_if.ready) begin
            if (expected_tokens.size() == 0) begin
                $display("%0t: token kind expected none, got %0d", $time,
                         tok_if.data.tok_kind);
                mismatches++;
            end else begin
                want = expected_tokens.pop_front();
                check_field("tok_kind", tok_if.data.tok_kind, want.tok_kind);
                check_field("literal_value", tok_if.data.literal_value, want.literal_value);
                check_field("word_offset", tok_if.data.word_offset, want.word_offset);
                check_field("word_length", tok_if.data.word_length, want.word_length);
                check_field("error_code", tok_if.data.error_code, want.error_code);
                check_field("error_line", tok_if.data.error_line, want.error_line);
                check_field("error_column", tok_if.data.error_column, want.error_column);
                check_field("run_end", tok_if.data.run_end, want.run_end);
            end
        end
    end

    // Ends the run if neither side has moved an item for too long.
    always @(posedge i_clk) begin
        if ((text_if.valid && text_if.ready) || (tok_if.valid && tok_if.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

endmodule
